// File: src/crcdf_pkg.sv
// Shared constants, result codes and the CRC-16/ARC byte update for the deframer.
package crcdf_pkg;

  localparam int MaxPayload = 1024;
  localparam int LenWidth   = 11;
  localparam int IdxWidth   = 10;

  localparam logic [7:0]  START_BYTE = 8'hFF;
  localparam logic [15:0] ARC_POLY   = 16'hA001;

  localparam logic [LenWidth-1:0] MAX_LEN = LenWidth'(MaxPayload);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // One byte through the reflected CRC, eight shift steps on 16 bits.
  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ ARC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/crc16_message_deframer.sv
// Top level of the start-word message deframer with CRC-16/ARC check.
//
//   channel   direction  handshake               word contents
//   input     in         in_valid / in_ready     rx_byte
//   result    out        out_valid / out_ready   result_kind, message_id, byte_index,
//                                                byte_value, received_crc, computed_crc
//   config    in         cfg_we                  cfg_data (payload length)
//
// One received word is taken per cycle when the result side keeps up. A word is
// decoded and folded into the CRC while it sits in the input register, once the
// result register is free or being emptied, and any result it causes is then
// registered in the result register and shown at the outputs.
// The CRC update of a whole byte is done combinationally in the decode stage.
// Reset (rst, synchronous) returns the deframer to hunting for the first start
// byte, clears the message state and the payload length, and empties both registers.
// A stalled result holds the decode stage; the input register then fills and
// in_ready drops, so no word is lost or repeated.
module crc16_message_deframer
  import crcdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LenWidth-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          result_kind,
  output logic [15:0]         message_id,
  output logic [IdxWidth-1:0] byte_index,
  output logic [7:0]          byte_value,
  output logic [15:0]         received_crc,
  output logic [15:0]         computed_crc
);

  localparam logic [2:0] PH_HUNT1  = 3'd0;
  localparam logic [2:0] PH_HUNT2  = 3'd1;
  localparam logic [2:0] PH_ID_HI  = 3'd2;
  localparam logic [2:0] PH_ID_LO  = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CRC_HI = 3'd5;
  localparam logic [2:0] PH_CRC_LO = 3'd6;

  // Configuration and message state.
  logic [LenWidth-1:0] payload_length;
  logic [2:0]          phase, phase_next;
  logic [15:0]         id_store, id_store_next;
  logic [LenWidth-1:0] payload_count, payload_count_next;
  logic [15:0]         running_crc, running_crc_next;
  logic [7:0]          crc_high_byte, crc_high_byte_next;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;

  // Decode results for the word in the input register.
  logic                emit;
  logic [1:0]          kind_next;
  logic [IdxWidth-1:0] index_next;
  logic [7:0]          value_next;
  logic [15:0]         rx_crc_next;

  logic                proc_fire;
  logic [LenWidth-1:0] eff_len;
  logic [LenWidth-1:0] count_inc;
  logic [15:0]         crc_upd;
  logic [15:0]         rx_crc_full;

  // The decode stage moves whenever the result register is free or being emptied.
  assign proc_fire = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || proc_fire;

  // Lengths above the maximum saturate.
  assign eff_len     = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
  assign count_inc   = payload_count + LenWidth'(1);
  assign rx_crc_full = {crc_high_byte, in_byte};

  // The ID high byte restarts the CRC from zero; every other CRC byte continues it.
  assign crc_upd = crc_arc_byte((phase == PH_ID_HI) ? 16'h0000 : running_crc, in_byte);

  always_comb begin
    phase_next         = phase;
    id_store_next      = id_store;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    emit               = 1'b0;
    kind_next          = KIND_DATA;
    index_next         = '0;
    value_next         = '0;
    rx_crc_next        = '0;
    case (phase)
      PH_HUNT1: begin
        if (in_byte == START_BYTE) begin
          phase_next = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        // A second byte that is not a start byte is dropped and the hunt restarts.
        phase_next = (in_byte == START_BYTE) ? PH_ID_HI : PH_HUNT1;
      end
      PH_ID_HI: begin
        running_crc_next   = crc_upd;
        id_store_next      = {in_byte, 8'h00};
        payload_count_next = '0;
        phase_next         = PH_ID_LO;
      end
      PH_ID_LO: begin
        running_crc_next   = crc_upd;
        id_store_next      = {id_store[15:8], in_byte};
        payload_count_next = '0;
        phase_next         = (eff_len == '0) ? PH_CRC_HI : PH_DATA;
      end
      PH_DATA: begin
        if (payload_count >= eff_len) begin
          // The length shrank during the frame: this byte is the CRC high byte.
          crc_high_byte_next = in_byte;
          phase_next         = PH_CRC_LO;
        end else begin
          running_crc_next   = crc_upd;
          emit               = 1'b1;
          kind_next          = KIND_DATA;
          index_next         = payload_count[IdxWidth-1:0];
          value_next         = in_byte;
          payload_count_next = count_inc;
          if (count_inc >= eff_len) begin
            phase_next = PH_CRC_HI;
          end
        end
      end
      PH_CRC_HI: begin
        crc_high_byte_next = in_byte;
        phase_next         = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        emit        = 1'b1;
        kind_next   = (rx_crc_full == running_crc) ? KIND_GOOD : KIND_BAD;
        rx_crc_next = rx_crc_full;
        phase_next  = PH_HUNT1;
      end
      default: begin
        phase_next = PH_HUNT1;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= '0;
    end else if (cfg_we) begin
      payload_length <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Message state advances once per decoded word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      id_store      <= '0;
      payload_count <= '0;
      running_crc   <= '0;
      crc_high_byte <= '0;
    end else if (proc_fire) begin
      phase         <= phase_next;
      id_store      <= id_store_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
    end
  end

  // Result register. A payload result carries the CRC including its own byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      result_kind  <= kind_next;
      message_id   <= id_store;
      byte_index   <= index_next;
      byte_value   <= value_next;
      received_crc <= rx_crc_next;
      computed_crc <= running_crc_next;
    end
  end

endmodule

// File: src/crcdf_checker.sv
// Port-level checker for the deframer and its bind to the top level.
module crcdf_checker
  import crcdf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          result_kind,
  input logic [15:0]         message_id,
  input logic [IdxWidth-1:0] byte_index,
  input logic [7:0]          byte_value,
  input logic [15:0]         received_crc,
  input logic [15:0]         computed_crc
);

  // A stalled result word stays valid and keeps its kind, message ID, index and computed CRC.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(message_id) && $stable(byte_index) && $stable(computed_crc))
    else $error("result word changed while stalled");

  // The verdict of a status word agrees with the two CRCs it carries; its index and value are zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_GOOD || result_kind == KIND_BAD) |->
      ((result_kind == KIND_GOOD) == (received_crc == computed_crc)) &&
      byte_index == '0 && byte_value == 8'h00)
    else $error("status word inconsistent");

  // A payload word carries no received CRC; only the three kinds appear.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == KIND_DATA && received_crc == 16'h0000) ||
      result_kind == KIND_GOOD || result_kind == KIND_BAD)
    else $error("bad payload word");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind crc16_message_deframer crcdf_checker u_crcdf_checker (.*);
